// ----- rtl/obis_value_extractor_core_assert.svh -----
// ---------------------------------------------------------------------------
// obis_value_extractor_core assertion macros
// Clocked assertion helpers shared by the RTL; compiled out with ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef OBIS_VALUE_EXTRACTOR_CORE_ASSERT_SVH
`define OBIS_VALUE_EXTRACTOR_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked out of reset
`define OVE_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define OVE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define OVE_ASSERT_IMPL(lbl, ante, cons, msg)
`define OVE_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- rtl/ove_pkg.sv -----
// ---------------------------------------------------------------------------
// ove_pkg
// Types, constants and code tables of the OBIS value extractor.
// ---------------------------------------------------------------------------
package ove_pkg;

	localparam int ENTRY_COUNT = 11;
	localparam int WIN_LEN     = 12;
	localparam int IDX_W       = 4;
	localparam int VAL_W       = 31;
	localparam int DIV_W       = 10;

	localparam logic [7:0] TAG_OCTSTR = 8'h09;
	localparam logic [7:0] OCT_LEN    = 8'h06;
	localparam logic [7:0] TAG_U32    = 8'h06;
	localparam logic [7:0] TAG_U16    = 8'h12;

	// element 11 is the newest byte
	typedef logic [WIN_LEN-1:0][7:0] win_t;
	// element 0 is the first code byte
	typedef logic [5:0][7:0] obis_code_t;

	// header flags shared by every entry cell
	typedef struct packed {
		logic u32_hdr;   // 09 06 at the window head, 06 tag before the last three bytes
		logic u16_hdr;   // 09 06 two bytes in, 12 tag before the last byte
	} hdr_t;

	function automatic obis_code_t mk_code(input logic [7:0] c, input logic [7:0] d);
		obis_code_t r;
		r[0] = 8'd1;
		r[1] = 8'd0;
		r[2] = c;
		r[3] = d;
		r[4] = 8'd0;
		r[5] = 8'd255;
		return r;
	endfunction

	function automatic obis_code_t obis_code(input logic [IDX_W-1:0] idx);
		obis_code_t r;
		case (idx)
			4'd0:    r = mk_code(8'd1, 8'd8);
			4'd1:    r = mk_code(8'd2, 8'd8);
			4'd2:    r = mk_code(8'd1, 8'd7);
			4'd3:    r = mk_code(8'd2, 8'd7);
			4'd4:    r = mk_code(8'd32, 8'd7);
			4'd5:    r = mk_code(8'd52, 8'd7);
			4'd6:    r = mk_code(8'd72, 8'd7);
			4'd7:    r = mk_code(8'd31, 8'd7);
			4'd8:    r = mk_code(8'd51, 8'd7);
			4'd9:    r = mk_code(8'd71, 8'd7);
			4'd10:   r = mk_code(8'd13, 8'd7);
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [DIV_W-1:0] obis_divisor(input logic [IDX_W-1:0] idx);
		logic [DIV_W-1:0] r;
		case (idx)
			4'd0, 4'd1, 4'd2, 4'd3: r = 10'd1;
			4'd4, 4'd5, 4'd6:       r = 10'd10;
			4'd7, 4'd8, 4'd9:       r = 10'd100;
			4'd10:                  r = 10'd1000;
			default:                r = 10'd1;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/ove_byte_window.sv -----
// ---------------------------------------------------------------------------
// ove_byte_window
// Twelve-byte shift line of preceding payload bytes plus shared header flags.
// ---------------------------------------------------------------------------
module ove_byte_window (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic          last,
	input  logic [7:0]    cur,
	output ove_pkg::win_t win,
	output ove_pkg::hdr_t hdr
);
	import ove_pkg::*;

	win_t win_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (step) begin
			if (last) begin
				win_q <= '0;
			end else begin
				win_q <= {cur, win_q[WIN_LEN-1:1]};
			end
		end
	end

	assign win         = win_q;
	assign hdr.u32_hdr = (win_q[0] == TAG_OCTSTR) && (win_q[1] == OCT_LEN) &&
	                     (win_q[8] == TAG_U32);
	assign hdr.u16_hdr = (win_q[2] == TAG_OCTSTR) && (win_q[3] == OCT_LEN) &&
	                     (win_q[10] == TAG_U16);

endmodule

// ----- rtl/ove_entry_cell.sv -----
// ---------------------------------------------------------------------------
// ove_entry_cell
// Match state of one OBIS entry and its slot in the result shift chain.
// ---------------------------------------------------------------------------
module ove_entry_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ove_pkg::obis_code_t        code,
	input  ove_pkg::win_t              win,
	input  ove_pkg::hdr_t              hdr,
	input  logic [7:0]                 cur,
	input  logic                       step,
	input  logic                       last,
	input  logic                       shift,
	input  logic                       nb_found,
	input  logic [ove_pkg::VAL_W-1:0]  nb_value,
	output logic                       snap_found,
	output logic [ove_pkg::VAL_W-1:0]  snap_value
);
	import ove_pkg::*;

	logic             done_q, valid_q;
	logic [VAL_W-1:0] value_q;
	logic             snap_found_q;
	logic [VAL_W-1:0] snap_value_q;

	logic             hit32, hit16;
	logic             done_d, valid_d;
	logic [VAL_W-1:0] value_d;
	logic [31:0]      v32;

	assign hit32 = hdr.u32_hdr && (win[7:2] == code);
	assign hit16 = hdr.u16_hdr && (win[9:4] == code);
	assign v32   = {win[9], win[10], win[11], cur};

	always_comb begin
		done_d  = done_q;
		valid_d = valid_q;
		value_d = value_q;
		if (!done_q) begin
			if (hit32) begin
				done_d = 1'b1;
				// top bit set: entry closed, value not usable
				if (!v32[31]) begin
					valid_d = 1'b1;
					value_d = v32[VAL_W-1:0];
				end
			end else if (hit16) begin
				done_d  = 1'b1;
				valid_d = 1'b1;
				value_d = {{(VAL_W-16){1'b0}}, win[11], cur};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= 1'b0;
			valid_q <= 1'b0;
			value_q <= '0;
		end else if (step) begin
			if (last) begin
				done_q  <= 1'b0;
				valid_q <= 1'b0;
				value_q <= '0;
			end else begin
				done_q  <= done_d;
				valid_q <= valid_d;
				value_q <= value_d;
			end
		end
	end

	// result slot: loaded at frame end, shifts toward the output on each pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_found_q <= 1'b0;
			snap_value_q <= '0;
		end else if (step && last) begin
			snap_found_q <= valid_d;
			snap_value_q <= value_d;
		end else if (shift) begin
			snap_found_q <= nb_found;
			snap_value_q <= nb_value;
		end
	end

	assign snap_found = snap_found_q;
	assign snap_value = snap_value_q;

endmodule

// ----- rtl/obis_value_extractor_core.sv -----
// ---------------------------------------------------------------------------
// obis_value_extractor_core
// Streaming OBIS value extractor over a decrypted meter payload.
// ---------------------------------------------------------------------------
// Takes one payload byte per cycle. A twelve-byte shift window feeds a row of
// eleven entry cells, one per OBIS code; each cell compares the window with
// its code every cycle and latches the first uint32 (tag 06) or uint16 (tag
// 12) value that follows "09 06 <code>". A uint32 with its top bit set closes
// the entry as not found. On the request flagged last_byte every cell copies
// its outcome into its result slot and clears; the slots form a shift chain
// that delivers eleven results, entry 0 first, one per cycle while out_ready
// is high, last_result marking entry 10. Bytes of the next frame are taken
// while the chain drains; only a further last_byte request waits until the
// previous frame's eleventh result has left. Throughput: one byte per cycle
// except for such a last_byte request, which is taken only once the chain
// has gone idle, so a frame shorter than the drain stalls on its last byte,
// and every out_ready low cycle during the drain delays it further.
// ---------------------------------------------------------------------------
module obis_value_extractor_core (
	input  logic                              clk,
	input  logic                              arst_n,
	// byte requests
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        data_byte,
	input  logic                              last_byte,
	// result requests
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ove_pkg::IDX_W-1:0]         entry_index,
	output logic                              found,
	output logic [ove_pkg::VAL_W-1:0]         raw_value,
	output logic [ove_pkg::DIV_W-1:0]         divisor,
	output logic                              last_result
);
	import ove_pkg::*;

	`include "obis_value_extractor_core_assert.svh"

	logic in_fire, out_fire, is_last;
	logic busy_q;
	logic [IDX_W-1:0] idx_q;

	win_t win;
	hdr_t hdr;

	// chain taps; the slot past the final cell shifts in zeros
	logic             chain_found [ENTRY_COUNT+1];
	logic [VAL_W-1:0] chain_value [ENTRY_COUNT+1];

	assign in_ready = !busy_q || !last_byte;
	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;
	assign is_last  = (idx_q == IDX_W'(ENTRY_COUNT - 1));

	ove_byte_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (in_fire),
		.last   (last_byte),
		.cur    (data_byte),
		.win    (win),
		.hdr    (hdr)
	);

	assign chain_found[ENTRY_COUNT] = 1'b0;
	assign chain_value[ENTRY_COUNT] = '0;

	for (genvar i = 0; i < ENTRY_COUNT; i++) begin : g_cell
		ove_entry_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.code       (obis_code(IDX_W'(i))),
			.win        (win),
			.hdr        (hdr),
			.cur        (data_byte),
			.step       (in_fire),
			.last       (last_byte),
			.shift      (out_fire),
			.nb_found   (chain_found[i+1]),
			.nb_value   (chain_value[i+1]),
			.snap_found (chain_found[i]),
			.snap_value (chain_value[i])
		);
	end

	// drain sequencing: index of the result at the chain head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (in_fire && last_byte) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (out_fire) begin
			if (is_last) begin
				busy_q <= 1'b0;
				idx_q  <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	assign out_valid   = busy_q;
	assign entry_index = idx_q;
	assign found       = chain_found[0];
	assign raw_value   = chain_value[0];
	assign divisor     = obis_divisor(idx_q);
	assign last_result = is_last;

	`OVE_ASSERT_IMPL(a_idx_range, busy_q, idx_q < IDX_W'(ENTRY_COUNT), "result index out of range")
	`OVE_ASSERT_NEXT(a_frame_load, in_fire && last_byte, busy_q && idx_q == '0, "frame end did not start drain")
	`OVE_ASSERT_NEXT(a_drain_end, out_fire && is_last, !busy_q, "drain did not stop after final result")
	`OVE_ASSERT_IMPL(a_no_value, busy_q && !found, raw_value == '0, "value without found flag")

endmodule
